[rtl/thfs_pkg.sv]
// shared constants, types and helpers of the two-hop follow suggestion block
package thfs_pkg;

  localparam int unsigned MAX_USERS = 64;
  localparam int unsigned USER_W    = 6;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ADDR_W    = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_USERS + 1);

  typedef logic [USER_W-1:0]    user_t;
  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [MAX_USERS-1:0] row_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_Q_SUBJ,
    ST_Q_DIR,
    ST_Q_GATH,
    ST_Q_FIN,
    ST_EMIT,
    ST_EMIT_NONE
  } state_e;

  typedef struct packed {
    logic  clr;
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    row_t  wr_data;
  } mem_req_t;

  // user id lies below the user count
  function automatic logic in_range(user_t u);
    return (USER_W + 1)'(u) < (USER_W + 1)'(MAX_USERS);
  endfunction

  function automatic addr_t to_addr(user_t u);
    return u[ADDR_W-1:0];
  endfunction

endpackage

[rtl/thfs_if.sv]
// valid/ready channel interfaces for commands and suggestions
interface thfs_req_if;
  logic             valid;
  logic             ready;
  thfs_pkg::cmd_t   cmd;
  thfs_pkg::user_t  subject_user;
  thfs_pkg::user_t  target_user;

  modport source (output valid, output cmd, output subject_user, output target_user,
                  input ready);
  modport sink   (input valid, input cmd, input subject_user, input target_user,
                  output ready);
endinterface

interface thfs_rsp_if;
  logic             valid;
  logic             ready;
  thfs_pkg::user_t  suggested_user;
  logic             none_found;
  logic             last;

  modport source (output valid, output suggested_user, output none_found, output last,
                  input ready);
  modport sink   (input valid, input suggested_user, input none_found, input last,
                  output ready);
endinterface

[rtl/thfs_row_mem.sv]
// follow matrix storage: one row per user, registered read, per-row valid bits
module thfs_row_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  thfs_pkg::mem_req_t req_i,
  output thfs_pkg::row_t     rd_data_o
);
  import thfs_pkg::*;

  row_t                 mem_q [MAX_USERS];
  logic [MAX_USERS-1:0] valid_q;
  row_t                 rd_raw_q;
  logic                 rd_hit_q;

  // valid bits: a row never written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_hit_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_raw_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_hit_q ? rd_raw_q : '0;

endmodule

[rtl/thfs_seq.sv]
// command sequencer: edge insert, two-hop gather over the rows, ordered emit
module thfs_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  thfs_req_if.sink           req_i,
  thfs_rsp_if.source         rsp_o,
  output thfs_pkg::mem_req_t mem_req_o,
  input  thfs_pkg::row_t     mem_rdata_i
);
  import thfs_pkg::*;

  state_e state_q, state_d;
  user_t  subj_q, subj_d;
  user_t  targ_q, targ_d;
  row_t   direct_q, direct_d;
  row_t   cand_q, cand_d;
  cnt_t   idx_q, idx_d;
  logic   pend_q, pend_d;
  addr_t  pend_idx_q, pend_idx_d;
  logic   out_valid_q, out_valid_d;
  user_t  out_user_q, out_user_d;
  logic   out_none_q, out_none_d;
  logic   out_last_q, out_last_d;

  logic   accept;
  logic   slot_free;
  logic   out_load;
  row_t   masked;
  row_t   rest;

  assign req_i.ready          = (state_q == ST_IDLE);
  assign accept               = req_i.valid && req_i.ready;
  assign slot_free            = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.suggested_user = out_user_q;
  assign rsp_o.none_found     = out_none_q;
  assign rsp_o.last           = out_last_q;

  assign masked = cand_q & ~direct_q & ~(row_t'(1) << subj_q);
  assign rest   = cand_q & ~(row_t'(1) << idx_q[ADDR_W-1:0]);

  always_comb begin
    state_d     = state_q;
    subj_d      = subj_q;
    targ_d      = targ_q;
    direct_d    = direct_q;
    cand_d      = cand_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    out_valid_d = out_valid_q;
    out_user_d  = out_user_q;
    out_none_d  = out_none_q;
    out_last_d  = out_last_q;
    out_load    = 1'b0;
    mem_req_o   = '0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    // fold in the row read last cycle when the subject follows that user
    if (pend_q && direct_q[pend_idx_q]) begin
      cand_d = cand_q | mem_rdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          subj_d = req_i.subject_user;
          targ_d = req_i.target_user;
          case (cmd_e'(req_i.cmd))
            CMD_CLEAR: begin
              mem_req_o.clr = 1'b1;
            end
            CMD_ADD: begin
              if (in_range(req_i.subject_user) && in_range(req_i.target_user)) begin
                state_d = ST_ADD_RD;
              end
            end
            CMD_QUERY: begin
              state_d = in_range(req_i.subject_user) ? ST_Q_SUBJ : ST_EMIT_NONE;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_RD: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = to_addr(subj_q);
        state_d           = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = to_addr(subj_q);
        mem_req_o.wr_data = mem_rdata_i | (row_t'(1) << targ_q);
        state_d           = ST_IDLE;
      end
      ST_Q_SUBJ: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = to_addr(subj_q);
        state_d           = ST_Q_DIR;
      end
      ST_Q_DIR: begin
        direct_d = mem_rdata_i;
        cand_d   = '0;
        idx_d    = '0;
        state_d  = ST_Q_GATH;
      end
      ST_Q_GATH: begin
        if (idx_q < CNT_W'(MAX_USERS)) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = idx_q[ADDR_W-1:0];
          pend_d            = 1'b1;
          pend_idx_d        = idx_q[ADDR_W-1:0];
          idx_d             = idx_q + cnt_t'(1);
        end else begin
          state_d = ST_Q_FIN;
        end
      end
      ST_Q_FIN: begin
        cand_d  = masked;
        idx_d   = '0;
        state_d = (masked == '0) ? ST_EMIT_NONE : ST_EMIT;
      end
      ST_EMIT: begin
        if (cand_q[idx_q[ADDR_W-1:0]]) begin
          if (slot_free) begin
            out_load    = 1'b1;
            out_valid_d = 1'b1;
            out_user_d  = USER_W'(idx_q);
            out_none_d  = 1'b0;
            out_last_d  = (rest == '0);
            cand_d      = rest;
            idx_d       = idx_q + cnt_t'(1);
            if (rest == '0) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          idx_d = idx_q + cnt_t'(1);
        end
      end
      ST_EMIT_NONE: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_user_d  = '0;
          out_none_d  = 1'b1;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    subj_q     <= subj_d;
    targ_q     <= targ_d;
    direct_q   <= direct_d;
    cand_q     <= cand_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    out_user_q <= out_user_d;
    out_none_q <= out_none_d;
    out_last_q <= out_last_d;
  end

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_none_q) |-> (out_last_q && out_user_q == '0))
    else $error("no-suggestion item without last mark or with nonzero id");

  a_no_write_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_GATH || state_q == ST_EMIT || state_q == ST_Q_FIN)
      |-> (!mem_req_o.wr_en && !mem_req_o.clr))
    else $error("row memory modified during a query");

  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT || state_q == ST_EMIT_NONE))
    else $error("result loaded outside the emit phase");

  a_last_ends_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (state_q == ST_IDLE))
    else $error("sequencer kept running after the last result");

endmodule

[rtl/two_hop_follow_suggest_core.sv]
// top level of the two-hop follow suggestion block: sequencer around the follow matrix
// a clear acts on acceptance, an edge add reads the subject row and writes it back, and a query
// reads the subject row, then one row per user in the gather pass, then scans the candidates bit by bit
// to emit the ids; one command at a time, and a query holds the input until its last result is loaded,
// and the emit scan waits while a loaded result has not been taken
// reset: graph empty at once through per-row valid bits, no clearing pass needed
module two_hop_follow_suggest_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  thfs_req_if.sink   req_i,
  thfs_rsp_if.source rsp_o
);
  import thfs_pkg::*;

  // request bundle from the sequencer to the follow matrix
  mem_req_t mem_req;
  // row data, valid in the cycle after the read request
  row_t     mem_rdata;

  // sequencer: takes commands, runs read-modify-write for edge adds,
  // sweeps the rows for a query and drives the output register
  thfs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // follow matrix: bit t of row u means user u follows user t
  thfs_row_mem u_row_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (mem_rdata)
  );

endmodule
